>>> src/assert_macros.svh
// assertion helpers for the rtl, included by array_list_engine_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked every clock, off while reset is high
`define ASSERT_SYNC(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// property checked every clock, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_SYNC(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> src/ale_pkg.sv
package ale_pkg;

  // operation codes on the op field
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_POP    = 3'd2;
  localparam logic [2:0] OP_PRINT  = 3'd3;
  localparam logic [2:0] OP_INSERT = 3'd4;

  // status codes on the result word
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int WordW = 32;

  // what one cell does this cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_WRAP,
    CELL_ADD
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [WordW-1:0]  operand;
  } cell_ctl_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_PRINT
  } state_t;

endpackage

>>> src/ale_cell.sv
module ale_cell (
  input  logic                     clk,
  input  ale_pkg::cell_ctl_t       ctl,
  input  logic [ale_pkg::WordW-1:0] prev,
  input  logic [ale_pkg::WordW-1:0] next,
  input  logic [ale_pkg::WordW-1:0] head,
  output logic [ale_pkg::WordW-1:0] entry
);
  import ale_pkg::*;

  // one stored entry, fed by its neighbors, the head entry or the operand
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD:       entry <= entry;
      CELL_LOAD:       entry <= ctl.operand;
      CELL_SHIFT_UP:   entry <= prev;
      CELL_SHIFT_DOWN: entry <= next;
      CELL_WRAP:       entry <= head;
      CELL_ADD:        entry <= entry + ctl.operand;
      default:         entry <= entry;
    endcase
  end

endmodule

>>> src/array_list_engine_core.sv
// latency: a result word is valid the cycle after its item is accepted
// a print's first word comes once the sequencer is in the print state and the result register is free
// throughput: one item per cycle for push, insert, add, pop and empty print while the result is not held
// print of n entries holds the request side while it streams its n words
// the request side stalls while a print is streaming or the result is held
// reset clears the count, the sequencer and the result valid; entries stay

`include "assert_macros.svh"

module array_list_engine_core #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] value,
  input  logic signed [15:0] position,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] data,
  output logic               last,
  output logic [1:0]         status
);
  import ale_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count, count_next;
  logic [CntW-1:0] idx, idx_next;
  logic [CntW-1:0] cnt_m1;
  logic [CntW-1:0] pos;
  state_t          state, state_next;

  logic rsp_free, accept, full, empty, print_step, print_done;
  logic do_push, do_insert, do_add, do_pop, start_print;
  logic res_load;
  logic [31:0] res_data;
  logic        res_last;
  logic [1:0]  res_status;

  logic [WordW-1:0] ent [DEPTH];
  cell_ctl_t        ctl [DEPTH];

  // handshake
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state == ST_PRINT) || !rsp_free;
  assign accept    = req_valid && !req_stall;

  assign full   = (count == CntW'(DEPTH));
  assign empty  = (count == '0);
  assign cnt_m1 = count - 1'b1;

  // decoded operations
  assign do_push     = accept && (op == OP_PUSH) && !full;
  assign do_insert   = accept && (op == OP_INSERT) && !full;
  assign do_add      = accept && (op == OP_ADD);
  assign do_pop      = accept && (op == OP_POP) && !empty;
  assign start_print = accept && (op == OP_PRINT) && !empty;
  assign print_step  = (state == ST_PRINT) && rsp_free;
  assign print_done  = print_step && (idx == cnt_m1);

  // insert position clamped to zero and to count
  always_comb begin
    if (position[15])
      pos = '0;
    else if (position > $signed({1'b0, 15'(count)}))
      pos = count;
    else
      pos = position[CntW-1:0];
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      ctl[i].operand = value;
      ctl[i].op      = CELL_HOLD;
      if (do_push && (CntW'(i) == count))
        ctl[i].op = CELL_LOAD;
      else if (do_insert && (CntW'(i) == pos))
        ctl[i].op = CELL_LOAD;
      else if (do_insert && (CntW'(i) > pos) && (CntW'(i) <= count))
        ctl[i].op = CELL_SHIFT_UP;
      else if (do_add)
        ctl[i].op = CELL_ADD;
      else if (print_step && (CntW'(i) < cnt_m1))
        ctl[i].op = CELL_SHIFT_DOWN;
      else if (print_step && (CntW'(i) == cnt_m1))
        ctl[i].op = CELL_WRAP;
    end

    ale_cell u_cell (
      .clk   (clk),
      .ctl   (ctl[i]),
      .prev  ((i == 0) ? value : ent[(i == 0) ? 0 : i - 1]),
      .next  ((i == DEPTH - 1) ? ent[0] : ent[(i == DEPTH - 1) ? i : i + 1]),
      .head  (ent[0]),
      .entry (ent[i])
    );
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start_print) state_next = ST_PRINT;
      ST_PRINT: if (print_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // result word and counters
  always_comb begin
    count_next = count;
    idx_next   = idx;
    res_load   = 1'b0;
    res_data   = '0;
    res_last   = 1'b1;
    res_status = STAT_OK;
    unique case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (accept) begin
          unique case (op) inside
            OP_PUSH, OP_INSERT: begin
              res_load = 1'b1;
              if (full) res_status = STAT_FULL;
              else count_next = count + 1'b1;
            end
            OP_ADD: res_load = 1'b1;
            OP_POP: begin
              res_load = 1'b1;
              if (empty) res_status = STAT_EMPTY;
              else count_next = cnt_m1;
            end
            OP_PRINT: begin
              res_load   = empty;
              res_status = STAT_EMPTY;
            end
            default: res_load = 1'b0;
          endcase
        end
      end
      ST_PRINT: begin
        if (print_step) begin
          res_load = 1'b1;
          res_data = ent[0];
          res_last = print_done;
          idx_next = idx + 1'b1;
        end
      end
      default: res_load = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (res_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      data   <= res_data;
      last   <= res_last;
      status <= res_status;
    end
  end

  `ASSERT_SYNC(a_count_range, clk, rst, count <= CntW'(DEPTH))
  `ASSERT_SYNC(a_print_enters, clk, rst, start_print |=> state == ST_PRINT)
  `ASSERT_SYNC(a_print_leaves, clk, rst, print_done |=> state == ST_IDLE)
  `ASSERT_SYNC(a_count_only_on_accept, clk, rst, !accept |=> $stable(count))

endmodule
